>>> rtl/iq_fm_subcarrier_injector_defines.svh
// Assertion macros shared by the IQ FM subcarrier injector RTL.
`ifndef IQ_FM_SUBCARRIER_INJECTOR_DEFINES_SVH
`define IQ_FM_SUBCARRIER_INJECTOR_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define IQFM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define IQFM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define IQFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/iqfm_pkg.sv
// Shared types, constants and the sine table generator for the IQ FM subcarrier injector.
`timescale 1ns / 1ps

package iqfm_pkg;

   localparam int PHASE_W      = 32;
   localparam int SAMPLE_W     = 16;
   localparam int BYTE_W       = 8;
   localparam int FILL_LEVEL_W = 14;
   localparam int DIVIDER_W    = 10;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int SINE_AMPL    = 20;

   localparam logic KIND_AUDIO = 1'b0;
   localparam logic KIND_IQ    = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEV_COEF     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_FILL     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_FILL    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOW_DIVIDER = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FAST_DIVIDER = 3'd5;

   localparam logic [FILL_LEVEL_W-1:0] LOW_FILL_RESET     = 14'd1900;
   localparam logic [FILL_LEVEL_W-1:0] HIGH_FILL_RESET    = 14'd2000;
   localparam logic [DIVIDER_W-1:0]    SLOW_DIVIDER_RESET = 10'd312;
   localparam logic [DIVIDER_W-1:0]    FAST_DIVIDER_RESET = 10'd311;

   localparam real HALF_PI = 1.5707963267948966;

   typedef struct packed {
      logic push;
      logic pop;
   } ring_ctrl_type;

   typedef struct packed {
      logic                    kind;
      logic [BYTE_W-1:0]       i_in;
      logic [BYTE_W-1:0]       q_in;
      logic                    dropped;
      logic [FILL_LEVEL_W-1:0] fill_level;
   } item_type;

   // Truncated 20*sin over a full turn, built from the first quadrant.
   // The step is a quarter turn divided by the number of entries.
   function automatic logic signed [BYTE_W-1:0] sine_entry(input int idx, input int entries,
                                                            input real step);
      int  quad;
      int  rem;
      int  u;
      int  mag;
      real x;
      quad = 0;
      if (4 * idx >= entries) quad = 1;
      if (4 * idx >= 2 * entries) quad = 2;
      if (4 * idx >= 3 * entries) quad = 3;
      rem = 4 * idx - quad * entries;
      u = quad[0] ? entries - rem : rem;
      if (u == 0) begin
         mag = 0;
      end else if (u >= entries) begin
         mag = SINE_AMPL;
      end else if (3 * u == entries) begin
         mag = SINE_AMPL / 2;
      end else begin
         x = $floor(real'(SINE_AMPL) * $sin(step * real'(u)));
         mag = int'(x);
         if (mag > SINE_AMPL) mag = SINE_AMPL;
      end
      return (quad >= 2) ? BYTE_W'(-mag) : BYTE_W'(mag);
   endfunction

endpackage

>>> rtl/iqfm_ring.sv
// Audio sample ring with live fill count and a register that always holds the head entry.
`timescale 1ns / 1ps
`include "iq_fm_subcarrier_injector_defines.svh"

module iqfm_ring
   import iqfm_pkg::*;
#(
   parameter int RING_DEPTH = 8192
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ring_ctrl_type                         ctrl,
   input  logic signed [SAMPLE_W-1:0]            push_data,
   output logic signed [SAMPLE_W-1:0]            head,
   output logic [$clog2(RING_DEPTH+1)-1:0]       fill,
   output logic [$clog2(RING_DEPTH+1)-1:0]       fill_next
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

   logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];

   logic [AW-1:0]              wr_idx_ff, wr_idx_in, wr_succ;
   logic [AW-1:0]              rd_idx_ff, rd_idx_in, rd_succ;
   logic [AW-1:0]              rd_addr;
   logic [FW-1:0]              fill_ff, fill_in;
   logic                       wrapped_ff, wrapped_in;
   logic signed [SAMPLE_W-1:0] head_ff, head_in;
   logic                       byp_valid_ff, byp_valid_in;
   logic signed [SAMPLE_W-1:0] byp_data_ff;
   logic                       ahead_valid_ff, ahead_valid_in;
   logic signed [SAMPLE_W-1:0] mem_q_ff;
   logic signed [SAMPLE_W-1:0] ahead_sample;

   assign wr_succ = (wr_idx_ff == LAST) ? '0 : wr_idx_ff + 1'b1;
   assign rd_succ = (rd_idx_ff == LAST) ? '0 : rd_idx_ff + 1'b1;

   assign wr_idx_in  = ctrl.push ? wr_succ : wr_idx_ff;
   assign rd_idx_in  = ctrl.pop ? rd_succ : rd_idx_ff;
   assign wrapped_in = wrapped_ff || (ctrl.push && wr_idx_ff == LAST);
   assign fill_in    = fill_ff + FW'(ctrl.push) - FW'(ctrl.pop);

   // The entry after the next head is read every cycle; a write to it in the same
   // cycle is caught by the bypass register.
   assign rd_addr        = (rd_idx_in == LAST) ? '0 : rd_idx_in + 1'b1;
   assign ahead_valid_in = wrapped_ff || (rd_addr < wr_idx_ff);
   assign byp_valid_in   = ctrl.push && (wr_idx_ff == rd_addr);

   // Entries that were never written read as zero.
   assign ahead_sample = byp_valid_ff   ? byp_data_ff :
                         ahead_valid_ff ? mem_q_ff    : '0;

   always_comb begin
      head_in = head_ff;
      if (ctrl.pop) begin
         head_in = ahead_sample;
      end else if (ctrl.push && wr_idx_ff == rd_idx_ff) begin
         head_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff      <= '0;
         rd_idx_ff      <= '0;
         fill_ff        <= '0;
         wrapped_ff     <= 1'b0;
         head_ff        <= '0;
         byp_valid_ff   <= 1'b0;
         ahead_valid_ff <= 1'b0;
      end else begin
         wr_idx_ff      <= wr_idx_in;
         rd_idx_ff      <= rd_idx_in;
         fill_ff        <= fill_in;
         wrapped_ff     <= wrapped_in;
         head_ff        <= head_in;
         byp_valid_ff   <= byp_valid_in;
         ahead_valid_ff <= ahead_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= push_data;
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         ring_mem[wr_idx_ff] <= push_data;
      end
      mem_q_ff <= ring_mem[rd_addr];
   end

   assign head      = head_ff;
   assign fill      = fill_ff;
   assign fill_next = fill_in;

   `IQFM_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FW'(RING_DEPTH), "ring fill exceeds depth")
   `IQFM_ASSERT_ALWAYS(a_index_fill, clock, reset, (wr_idx_ff == rd_idx_ff) == (fill_ff == '0 || fill_ff == FW'(RING_DEPTH)), "ring indexes disagree with fill")
   `IQFM_ASSERT_NEXT(a_head_write, clock, reset, ctrl.push && !ctrl.pop && wr_idx_ff == rd_idx_ff, head_ff == $past(push_data), "write into empty ring missed the head")

endmodule

>>> rtl/iq_fm_subcarrier_injector.sv
// Top level of the IQ FM subcarrier injector: registers, ring control and the mixing pipeline.
`timescale 1ns / 1ps
`include "iq_fm_subcarrier_injector_defines.svh"

// The block takes one item per clock while the result side does not stall and returns
// one result per item, in order, via stages s1 to s4 and the result register. Audio items
// append to the sample ring or are flagged as dropped when it is full; IQ items step
// the carrier phase by phase_step plus the head sample times dev_coef and add the sine
// and the quarter-turn-delayed sine to I and Q. The phase accumulator, updated once per
// IQ item in the third stage, is the only loop in the datapath and holds the single-clock
// rate. The ring is a one-port-write, one-port-read memory with no clearing pass after
// reset: entries never written read as zero. Configuration writes are taken at any time
// and must be made while no item is in flight.
module iq_fm_subcarrier_injector
   import iqfm_pkg::*;
#(
   parameter int RING_DEPTH   = 8192,
   parameter int SINE_ENTRIES = 2048
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [SAMPLE_W-1:0]    req_audio_sample,
   input  logic [BYTE_W-1:0]             req_i_in,
   input  logic [BYTE_W-1:0]             req_q_in,
   input  logic                          req_block_end,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [BYTE_W-1:0]             rsp_i_out,
   output logic [BYTE_W-1:0]             rsp_q_out,
   output logic                          rsp_dropped,
   output logic [FILL_LEVEL_W-1:0]       rsp_fill_level,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int FW      = $clog2(RING_DEPTH + 1);
   localparam int CW      = (FW > FILL_LEVEL_W) ? FW : FILL_LEVEL_W;
   localparam int SW      = $clog2(SINE_ENTRIES);
   localparam int MW      = $clog2(SINE_ENTRIES + 1);
   localparam int QUARTER = SINE_ENTRIES / 4;
   localparam real QUARTER_STEP = HALF_PI / SINE_ENTRIES;

   // Configuration registers.
   logic [PHASE_W-1:0]      phase_step_ff;
   logic [PHASE_W-1:0]      dev_coef_ff;
   logic [FILL_LEVEL_W-1:0] low_fill_ff;
   logic [FILL_LEVEL_W-1:0] high_fill_ff;
   logic [DIVIDER_W-1:0]    slow_div_ff;
   logic [DIVIDER_W-1:0]    fast_div_ff;
   logic                    csr_write;

   // Acceptance and ring control.
   logic                       pipe_en;
   logic                       accept;
   logic                       is_iq;
   logic                       ring_full;
   ring_ctrl_type              ring_ctrl;
   logic signed [SAMPLE_W-1:0] ring_head;
   logic [FW-1:0]              ring_fill;
   logic [FW-1:0]              ring_fill_next;
   logic [CW-1:0]              fill_wide;
   logic [DIVIDER_W:0]         frac_inc;
   logic                       frac_tick;
   logic [DIVIDER_W-1:0]       rate_frac_ff, rate_frac_in;
   logic [DIVIDER_W-1:0]       active_div_ff, active_div_in;
   item_type                   item_in;

   // Pipeline.
   logic                       s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   item_type                   s1_item_ff, s2_item_ff, s3_item_ff, s4_item_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic [PHASE_W-1:0]         sample_ext;
   logic [PHASE_W-1:0]         product;
   logic [PHASE_W-1:0]         s2_product_ff;
   logic [PHASE_W-1:0]         phase_ff;
   logic [PHASE_W+MW-1:0]      phase_prod;
   logic [MW-1:0]              idx_full;
   logic [SW-1:0]              idx_in;
   logic [SW:0]                qsum;
   logic [SW:0]                qwrap;
   logic [SW-1:0]              qidx_in;
   logic signed [BYTE_W-1:0]   s4_sine_i_ff, s4_sine_q_ff;
   logic signed [BYTE_W-1:0]   sine_rom [SINE_ENTRIES];
   logic [BYTE_W-1:0]          i_out_in, q_out_in;

   logic                       rsp_valid_ff;
   logic [BYTE_W-1:0]          rsp_i_out_ff, rsp_q_out_ff;
   logic                       rsp_dropped_ff;
   logic [FILL_LEVEL_W-1:0]    rsp_fill_level_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         dev_coef_ff   <= '0;
         low_fill_ff   <= LOW_FILL_RESET;
         high_fill_ff  <= HIGH_FILL_RESET;
         slow_div_ff   <= SLOW_DIVIDER_RESET;
         fast_div_ff   <= FAST_DIVIDER_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PHASE_STEP:   phase_step_ff <= csr_data;
            REG_DEV_COEF:     dev_coef_ff   <= csr_data;
            REG_LOW_FILL:     low_fill_ff   <= csr_data[FILL_LEVEL_W-1:0];
            REG_HIGH_FILL:    high_fill_ff  <= csr_data[FILL_LEVEL_W-1:0];
            REG_SLOW_DIVIDER: slow_div_ff   <= csr_data[DIVIDER_W-1:0];
            REG_FAST_DIVIDER: fast_div_ff   <= csr_data[DIVIDER_W-1:0];
            default: ;
         endcase
      end
   end

   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en;
   assign accept    = req_valid && pipe_en;
   assign is_iq     = (req_kind == KIND_IQ);
   assign ring_full = (ring_fill == FW'(RING_DEPTH));

   assign frac_inc  = {1'b0, rate_frac_ff} + 1'b1;
   assign frac_tick = frac_inc > {1'b0, active_div_ff};

   always_comb begin
      ring_ctrl.push = accept && !is_iq && !ring_full;
      ring_ctrl.pop  = accept && is_iq && frac_tick && (ring_fill != '0);
   end

   iqfm_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ring_ctrl),
      .push_data (req_audio_sample),
      .head      (ring_head),
      .fill      (ring_fill),
      .fill_next (ring_fill_next)
   );

   assign fill_wide = CW'(ring_fill_next);

   always_comb begin
      rate_frac_in  = rate_frac_ff;
      active_div_in = active_div_ff;
      if (accept && is_iq) begin
         rate_frac_in = frac_tick ? '0 : frac_inc[DIVIDER_W-1:0];
         if (req_block_end) begin
            if (fill_wide < CW'(low_fill_ff)) begin
               active_div_in = slow_div_ff;
            end
            if (fill_wide > CW'(high_fill_ff)) begin
               active_div_in = fast_div_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_frac_ff  <= '0;
         active_div_ff <= SLOW_DIVIDER_RESET;
      end else begin
         rate_frac_ff  <= rate_frac_in;
         active_div_ff <= active_div_in;
      end
   end

   always_comb begin
      item_in.kind       = req_kind;
      item_in.i_in       = req_i_in;
      item_in.q_in       = req_q_in;
      item_in.dropped    = !is_iq && ring_full;
      item_in.fill_level = fill_wide[FILL_LEVEL_W-1:0];
   end

   assign sample_ext = {{(PHASE_W-SAMPLE_W){s1_sample_ff[SAMPLE_W-1]}}, s1_sample_ff};
   assign product    = sample_ext * dev_coef_ff;

   assign phase_prod = (PHASE_W+MW)'(phase_ff) * (PHASE_W+MW)'(SINE_ENTRIES);
   assign idx_full   = phase_prod[PHASE_W+MW-1:PHASE_W];
   assign idx_in     = idx_full[SW-1:0];
   assign qsum       = {1'b0, idx_in} + (SW+1)'(SINE_ENTRIES - QUARTER);
   assign qwrap      = (qsum >= (SW+1)'(SINE_ENTRIES)) ? qsum - (SW+1)'(SINE_ENTRIES) : qsum;
   assign qidx_in    = qwrap[SW-1:0];

   for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
      assign sine_rom[g] = sine_entry(g, SINE_ENTRIES, QUARTER_STEP);
   end

   assign i_out_in = (s4_item_ff.kind == KIND_IQ) ?
                     s4_item_ff.i_in + $unsigned(s4_sine_i_ff) : '0;
   assign q_out_in = (s4_item_ff.kind == KIND_IQ) ?
                     s4_item_ff.q_in + $unsigned(s4_sine_q_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (pipe_en && s2_valid_ff && s2_item_ff.kind == KIND_IQ) begin
         phase_ff <= phase_ff + phase_step_ff + s2_product_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_item_ff        <= item_in;
         s1_sample_ff      <= ring_head;
         s2_item_ff        <= s1_item_ff;
         s2_product_ff     <= product;
         s3_item_ff        <= s2_item_ff;
         s4_item_ff        <= s3_item_ff;
         s4_sine_i_ff      <= sine_rom[idx_in];
         s4_sine_q_ff      <= sine_rom[qidx_in];
         rsp_i_out_ff      <= i_out_in;
         rsp_q_out_ff      <= q_out_in;
         rsp_dropped_ff    <= s4_item_ff.dropped;
         rsp_fill_level_ff <= s4_item_ff.fill_level;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_i_out      = rsp_i_out_ff;
   assign rsp_q_out      = rsp_q_out_ff;
   assign rsp_dropped    = rsp_dropped_ff;
   assign rsp_fill_level = rsp_fill_level_ff;

   `IQFM_ASSERT_ALWAYS(a_ready_free, clock, reset, !(req_ready && rsp_valid && !rsp_ready), "input taken while the result register is blocked")
   `IQFM_ASSERT_NEXT(a_push_fill, clock, reset, accept && !is_iq && !ring_full, ring_fill == $past(ring_fill) + 1'b1, "accepted audio sample did not raise the fill")
   `IQFM_ASSERT_IMPLIES(a_drop_zero, clock, reset, rsp_valid && rsp_dropped, rsp_i_out == '0 && rsp_q_out == '0, "dropped sample result carries IQ data")

endmodule
